FILE: design/pngunf_pkg.sv
// ============================================================================
// pngunf_pkg
// Shared types and constants for the PNG scanline unfilter (RGBA, 8 bit).
// ============================================================================
package pngunf_pkg;

  // Bytes per RGBA pixel; also the predictor distance
  localparam int unsigned BYTES_PER_PIXEL = 4;

  // Width of the image-width configuration register
  localparam int unsigned CFG_WIDTH_W = 11;

  // PNG filter types as carried in the filter byte
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  // One byte of the inflated stream
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_image;
  } in_item_t;

  // One reconstructed byte or an error report
  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       filter_error;
  } out_item_t;

endpackage

FILE: design/pngunf_ram.sv
// ============================================================================
// pngunf_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when the read enable is high.
// ============================================================================
module pngunf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; hold the last word while the read enable is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/pngunf_predict.sv
// ============================================================================
// pngunf_predict
// Predictor and reconstruction for one sample: none, sub, up, average and
// Paeth, from the left (a), up (b) and upper-left (c) bytes.
// ============================================================================
module pngunf_predict (
  input  pngunf_pkg::filter_t filter,
  input  logic [7:0]          sample,
  input  logic [7:0]          a,
  input  logic [7:0]          b,
  input  logic [7:0]          c,
  output logic [7:0]          recon
);

  logic [8:0] sum_ab;
  logic [8:0] twice_c;
  logic [7:0] pa;
  logic [7:0] pb;
  logic [8:0] pc;
  logic [7:0] paeth;
  logic [7:0] pred;

  // Paeth distances: |b-c|, |a-c|, |a+b-2c|
  always_comb begin
    sum_ab  = {1'b0, a} + {1'b0, b};
    twice_c = {c, 1'b0};
    pa      = (b > c) ? (b - c) : (c - b);
    pb      = (a > c) ? (a - c) : (c - a);
    pc      = (sum_ab > twice_c) ? (sum_ab - twice_c) : (twice_c - sum_ab);
  end

  // Resolve ties in the order a, b, c
  always_comb begin
    priority if (({1'b0, pa} <= {1'b0, pb}) && ({1'b0, pa} <= pc)) begin
      paeth = a;
    end else if ({1'b0, pb} <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  end

  // Select the predictor and add it to the filtered sample
  always_comb begin
    unique case (filter)
      pngunf_pkg::FILT_SUB:   pred = a;
      pngunf_pkg::FILT_UP:    pred = b;
      pngunf_pkg::FILT_AVG:   pred = sum_ab[8:1];
      pngunf_pkg::FILT_PAETH: pred = paeth;
      default:                pred = 8'd0;
    endcase
    recon = sample + pred;
  end

endmodule

FILE: design/png_scanline_unfilter_rgba8_unit.sv
// ============================================================================
// png_scanline_unfilter_rgba8_unit
// PNG scanline unfilter for 8-bit RGBA: one inflated byte in, at most one
// reconstructed byte (or one filter error) out. The previous row lives in
// a single-port-read RAM that is read at a byte's column and rewritten
// with the reconstructed value once that byte leaves the reconstruct stage.
//
//   channel  ports                          payload      direction
//   -------  -----------------------------  -----------  ---------
//   input    in_valid / in_ready / in_data  in_item_t    in
//   result   out_valid / out_ready / out_data out_item_t out
//   config   cfg_wr_en / cfg_wr_data        image width  in
//
// Takes one byte per cycle while the output is not stalled; an accepted byte
// loads the reconstruct stage and the RAM read, and its result then moves
// into the output register.
// The prior-row RAM gives the up byte from a registered read;
// the left byte is four bytes back, so it is always ready in time.
// Reset is synchronous; the RAM is not cleared, since the first row of an
// image uses zero in place of its contents.
// A stalled output holds the reconstruct stage, which in turn drops in_ready.
// ============================================================================
module png_scanline_unfilter_rgba8_unit #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  pngunf_pkg::in_item_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output pngunf_pkg::out_item_t                 out_data,
  input  logic                                  cfg_wr_en,
  input  logic [pngunf_pkg::CFG_WIDTH_W-1:0]    cfg_wr_data
);

  localparam int unsigned LINE_BYTES = MAX_WIDTH * pngunf_pkg::BYTES_PER_PIXEL;
  localparam int unsigned AW         = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int unsigned LEN_W      = AW + 1;

  // What the reconstruct stage does with its entry
  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_CLEAR,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [7:0]          sample;
    logic [AW-1:0]       pos;
    pngunf_pkg::filter_t filter;
    logic                first_row;
    logic                last;
  } stage_t;

  // Configuration: row length in bytes, clamped at write time
  logic [LEN_W-1:0] row_len_r, row_len_nxt;
  logic [31:0]      width_clamped;

  // Row control state
  logic [AW-1:0]       col_r, col_nxt;
  logic                expect_r, expect_nxt;
  logic                first_r, first_nxt;
  logic                halted_r, halted_nxt;
  pngunf_pkg::filter_t filt_r, filt_nxt;

  // Reconstruct stage
  logic   s1_valid_r, s1_valid_nxt;
  stage_t s1_r, s1_nxt;
  logic   s1_item;
  logic   s1_has_result;
  logic   s1_move;

  // Left and upper-left history, four bytes deep
  logic [31:0] left_r, left_nxt;
  logic [31:0] upleft_r, upleft_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  pngunf_pkg::out_item_t out_data_r, out_data_nxt;

  // Stage-0 working values
  logic          in_fire;
  logic          start;
  logic [AW-1:0] col_eff;
  logic [LEN_W-1:0] col_inc;

  // Memory and predictor signals
  logic [7:0] ram_rd_data;
  logic [7:0] up_byte;
  logic [7:0] recon;
  logic       ram_wr_en;

  // Handshake
  assign s1_has_result = (s1_r.kind != KIND_CLEAR);
  assign s1_move       = s1_valid_r && (!s1_has_result || !out_valid_r || out_ready);
  assign in_ready      = !s1_valid_r || s1_move;
  assign in_fire       = in_valid && in_ready;

  // Clamp the configured width to 1..MAX_WIDTH and turn it into bytes
  always_comb begin
    width_clamped = 32'(cfg_wr_data);
    if (width_clamped == 32'd0) begin
      width_clamped = 32'd1;
    end
    if (width_clamped > 32'(MAX_WIDTH)) begin
      width_clamped = 32'(MAX_WIDTH);
    end
    row_len_nxt = row_len_r;
    if (cfg_wr_en) begin
      row_len_nxt = LEN_W'(width_clamped * pngunf_pkg::BYTES_PER_PIXEL);
    end
  end

  // Decode the accepted byte: filter byte, sample, or ignored while halted
  always_comb begin
    start      = in_data.start_image;
    col_eff    = start ? '0 : col_r;
    col_inc    = {1'b0, col_eff} + LEN_W'(1);

    col_nxt    = col_r;
    expect_nxt = expect_r;
    first_nxt  = first_r;
    halted_nxt = halted_r;
    filt_nxt   = filt_r;
    s1_item    = 1'b0;

    s1_nxt.kind      = KIND_SAMPLE;
    s1_nxt.sample    = in_data.data_byte;
    s1_nxt.pos       = col_eff;
    s1_nxt.filter    = filt_r;
    s1_nxt.first_row = start ? 1'b1 : first_r;
    s1_nxt.last      = (col_inc >= row_len_r);

    if (in_fire) begin
      if (start) begin
        halted_nxt = 1'b0;
        expect_nxt = 1'b1;
        first_nxt  = 1'b1;
        col_nxt    = '0;
      end
      priority if (halted_r && !start) begin
        // drop bytes until the next image start
        s1_item = 1'b0;
      end else if (expect_r || start) begin
        s1_item = 1'b1;
        if (in_data.data_byte > 8'(pngunf_pkg::FILT_PAETH)) begin
          halted_nxt  = 1'b1;
          s1_nxt.kind = KIND_ERROR;
        end else begin
          filt_nxt    = pngunf_pkg::filter_t'(in_data.data_byte[2:0]);
          expect_nxt  = 1'b0;
          col_nxt     = '0;
          s1_nxt.kind = KIND_CLEAR;
        end
      end else begin
        s1_item = 1'b1;
        if (s1_nxt.last) begin
          expect_nxt = 1'b1;
          first_nxt  = 1'b0;
          col_nxt    = '0;
        end else begin
          col_nxt = col_inc[AW-1:0];
        end
      end
    end
  end

  // Advance the reconstruct stage
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = s1_item;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Prior-row byte: zero on the first row of an image
  assign up_byte = s1_r.first_row ? 8'd0 : ram_rd_data;

  pngunf_predict u_predict (
    .filter (s1_r.filter),
    .sample (s1_r.sample),
    .a      (left_r[31:24]),
    .b      (up_byte),
    .c      (upleft_r[31:24]),
    .recon  (recon)
  );

  assign ram_wr_en = s1_move && (s1_r.kind == KIND_SAMPLE);

  pngunf_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_prior_line (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (s1_r.pos),
    .wr_data (recon),
    .rd_en   (in_fire),
    .rd_addr (col_eff),
    .rd_data (ram_rd_data)
  );

  // Shift history on a sample, clear it on a filter byte
  always_comb begin
    left_nxt   = left_r;
    upleft_nxt = upleft_r;
    if (s1_move) begin
      unique case (s1_r.kind)
        KIND_SAMPLE: begin
          left_nxt   = {left_r[23:0], recon};
          upleft_nxt = {upleft_r[23:0], up_byte};
        end
        KIND_CLEAR: begin
          left_nxt   = '0;
          upleft_nxt = '0;
        end
        default: begin
          left_nxt   = left_r;
          upleft_nxt = upleft_r;
        end
      endcase
    end
  end

  // Load the output register, drop it once taken
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_move && s1_has_result) begin
      out_valid_nxt = 1'b1;
      if (s1_r.kind == KIND_ERROR) begin
        out_data_nxt.pixel_byte   = 8'd0;
        out_data_nxt.row_end      = 1'b0;
        out_data_nxt.filter_error = 1'b1;
      end else begin
        out_data_nxt.pixel_byte   = recon;
        out_data_nxt.row_end      = s1_r.last;
        out_data_nxt.filter_error = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r   <= LEN_W'(pngunf_pkg::BYTES_PER_PIXEL);
      col_r       <= '0;
      expect_r    <= 1'b1;
      first_r     <= 1'b1;
      halted_r    <= 1'b0;
      filt_r      <= pngunf_pkg::FILT_NONE;
      s1_valid_r  <= 1'b0;
      left_r      <= '0;
      upleft_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_len_r   <= row_len_nxt;
      col_r       <= col_nxt;
      expect_r    <= expect_nxt;
      first_r     <= first_nxt;
      halted_r    <= halted_nxt;
      filt_r      <= filt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      left_r      <= left_nxt;
      upleft_r    <= upleft_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
